@@ rtl/core/tmpg_pkg.sv @@
`default_nettype none

package tmpg_pkg;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // store regions
  localparam logic [1:0] REGION_CELL    = 2'd0;
  localparam logic [1:0] REGION_PALETTE = 2'd1;
  localparam logic [1:0] REGION_FONT    = 2'd2;
  localparam logic [1:0] REGION_CURSOR  = 2'd3;

  // cursor register offsets
  localparam logic [14:0] CURSOR_ENABLE_OFS = 15'd0;
  localparam logic [14:0] CURSOR_COLOUR_OFS = 15'd1;
  localparam logic [14:0] CURSOR_COLUMN_OFS = 15'd2;
  localparam logic [14:0] CURSOR_ROW_OFS    = 15'd3;

  // underscore glyph of font 0
  localparam logic [7:0] CURSOR_CODE = 8'd95;

  // bytes in one font of 256 glyphs
  localparam int FONT_BYTES = 2048;

  // pixel sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL,
    S_GLYPH,
    S_SEL,
    S_QUOT,
    S_PAL,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/tmpg_ram.sv @@
`default_nettype none

module tmpg_ram #(
  parameter int LANES = 1,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic                 clk,
  input  wire logic [LANES-1:0]     we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [LANES*8-1:0]   wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [LANES*8-1:0]   rdata
);

  logic [LANES*8-1:0] mem [DEPTH];

  // byte-lane write
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (we[i]) begin
        mem[waddr][i*8 +: 8] <= wdata[i*8 +: 8];
      end
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/text_mode_pixel_generator.sv @@
// Pixel item: the sequencer runs the cell read, cursor and cell glyph reads on one
// glyph port, palette index reduction and palette read, then loads the result.
// Throughput: one write item per cycle when idle, none while a pixel item is in flight.
// A finished pixel waits in the output register while the next item is accepted.
// Reset clears the sequencer, output valid and cursor registers; the cell, palette
// and font stores are not cleared and read as undefined until written.
`default_nettype none

module text_mode_pixel_generator #(
  parameter int CELL_COLUMNS    = 80,
  parameter int CELL_ROWS       = 60,
  parameter int FONT_COUNT      = 4,
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [1:0]  region,
  input  wire logic [14:0] byte_offset,
  input  wire logic [7:0]  write_byte,
  input  wire logic [9:0]  pixel_x,
  input  wire logic [8:0]  pixel_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue
);

  import tmpg_pkg::*;

  localparam int CELLS      = CELL_COLUMNS * CELL_ROWS;
  localparam int CELL_AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int GLYPH_DEP  = FONT_COUNT * FONT_BYTES;
  localparam int GLYPH_AW   = $clog2(GLYPH_DEP);
  localparam int PAL_AW     = $clog2(PALETTE_ENTRIES);
  localparam int PAL_RECIP  = (65536 + PALETTE_ENTRIES - 1) / PALETTE_ENTRIES;
  localparam int CELL_LIMIT = CELLS * 4;
  localparam int PAL_LIMIT  = PALETTE_ENTRIES * 4;
  localparam int X_LIMIT    = CELL_COLUMNS * 8;
  localparam int Y_LIMIT    = CELL_ROWS * 8;

  state_t state;
  state_t state_next;

  logic       accept;
  logic       store_we;
  logic       out_load;
  logic [9:0] px;
  logic [8:0] py;

  logic       cursor_enable;
  logic [7:0] cursor_colour;
  logic [7:0] cursor_column;
  logic [7:0] cursor_row;

  logic [16:0] off_ext;
  logic [3:0]  lane_mask;

  logic [3:0]          cell_we;
  logic [CELL_AW-1:0]  cell_raddr;
  logic [31:0]         cell_rdata;
  logic [0:0]          glyph_we;
  logic [GLYPH_AW-1:0] glyph_raddr;
  logic [7:0]          glyph_rdata;
  logic [2:0]          pal_we;
  logic [PAL_AW-1:0]   pal_raddr;
  logic [23:0]         pal_rdata;

  logic [13:0] cell_index;
  logic        in_grid;
  logic [9:0]  cur_dx;
  logic [8:0]  cur_dy;
  logic        cur_inside;
  logic [1:0]  font_sel;
  logic [12:0] cell_glyph_addr;
  logic [12:0] cur_glyph_addr;

  logic        cursor_hit;
  logic [7:0]  cell_fg;
  logic [7:0]  cell_bg;
  logic [7:0]  pal_index;
  logic [7:0]  pal_quot;
  logic        black;
  logic [24:0] quot_prod;
  logic [15:0] pal_sub;
  logic [15:0] pal_rem;

  // handshake
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign store_we = accept && (kind == KIND_WRITE);

  // write decode
  assign off_ext   = 17'(byte_offset);
  assign lane_mask = 4'b0001 << byte_offset[1:0];

  always_comb begin
    cell_we  = '0;
    glyph_we = '0;
    pal_we   = '0;
    if (store_we) begin
      case (region)
        REGION_CELL: begin
          if (off_ext < 17'(CELL_LIMIT)) cell_we = lane_mask;
        end
        REGION_PALETTE: begin
          if (off_ext < 17'(PAL_LIMIT)) pal_we = lane_mask[2:0];
        end
        REGION_FONT: begin
          if (off_ext < 17'(GLYPH_DEP)) glyph_we = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_enable <= 1'b0;
      cursor_colour <= '0;
      cursor_column <= '0;
      cursor_row    <= '0;
    end else if (store_we && region == REGION_CURSOR) begin
      if (byte_offset == CURSOR_ENABLE_OFS) cursor_enable <= (write_byte != 8'd0);
      if (byte_offset == CURSOR_COLOUR_OFS) cursor_colour <= write_byte;
      if (byte_offset == CURSOR_COLUMN_OFS) cursor_column <= write_byte;
      if (byte_offset == CURSOR_ROW_OFS)    cursor_row    <= write_byte;
    end
  end

  // pixel position capture
  always_ff @(posedge clk) begin
    if (accept) begin
      px <= pixel_x;
      py <= pixel_y;
    end
  end

  // cell address and grid test
  assign cell_index = 14'(py[8:3]) * 14'(CELL_COLUMNS) + 14'(px[9:3]);
  assign cell_raddr = cell_index[CELL_AW-1:0];
  assign in_grid    = (11'(px) < 11'(X_LIMIT)) && (11'(py) < 11'(Y_LIMIT));

  // cursor window
  assign cur_dx     = px - 10'(cursor_column);
  assign cur_dy     = py - 9'(cursor_row);
  assign cur_inside = cursor_enable && (px >= 10'(cursor_column)) &&
                      (py >= 9'(cursor_row)) && (cur_dx < 10'd8) && (cur_dy < 9'd8);

  // glyph addresses: cursor row first, then the cell row
  assign font_sel = (32'(cell_rdata[1:0]) >= FONT_COUNT) ? 2'd0 : cell_rdata[1:0];
  assign cell_glyph_addr = {font_sel, cell_rdata[31:24], py[2:0]};
  assign cur_glyph_addr  = {2'd0, CURSOR_CODE, cur_dy[2:0]};
  assign glyph_raddr = (state == S_CELL) ? cur_glyph_addr[GLYPH_AW-1:0]
                                         : cell_glyph_addr[GLYPH_AW-1:0];

  // palette index reduction modulo the entry count
  assign quot_prod = 25'(pal_index) * 25'(PAL_RECIP);
  assign pal_sub   = 16'(pal_quot) * 16'(PALETTE_ENTRIES);
  assign pal_rem   = 16'(pal_index) - pal_sub;
  assign pal_raddr = pal_rem[PAL_AW-1:0];

  // pixel datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_GLYPH: begin
        cursor_hit <= cur_inside && glyph_rdata[~cur_dx[2:0]];
        cell_fg    <= cell_rdata[15:8];
        cell_bg    <= cell_rdata[23:16];
      end
      S_SEL: begin
        if (cursor_hit) pal_index <= cursor_colour;
        else if (glyph_rdata[~px[2:0]]) pal_index <= cell_fg;
        else pal_index <= cell_bg;
        black <= !cursor_hit && !in_grid;
      end
      S_QUOT: begin
        pal_quot <= quot_prod[23:16];
      end
      default: begin
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && kind == KIND_PIXEL) state_next = S_CELL;
      end
      S_CELL:  state_next = S_GLYPH;
      S_GLYPH: state_next = S_SEL;
      S_SEL:   state_next = S_QUOT;
      S_QUOT:  state_next = S_PAL;
      S_PAL:   state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red   <= black ? 8'd0 : pal_rdata[7:0];
      green <= black ? 8'd0 : pal_rdata[15:8];
      blue  <= black ? 8'd0 : pal_rdata[23:16];
    end
  end

  // stores
  tmpg_ram #(
    .LANES (4),
    .DEPTH (CELLS),
    .AW    (CELL_AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (CELL_AW'(off_ext >> 2)),
    .wdata ({4{write_byte}}),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  tmpg_ram #(
    .LANES (1),
    .DEPTH (GLYPH_DEP),
    .AW    (GLYPH_AW)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (glyph_we),
    .waddr (byte_offset[GLYPH_AW-1:0]),
    .wdata (write_byte),
    .raddr (glyph_raddr),
    .rdata (glyph_rdata)
  );

  tmpg_ram #(
    .LANES (3),
    .DEPTH (PALETTE_ENTRIES),
    .AW    (PAL_AW)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (PAL_AW'(off_ext >> 2)),
    .wdata ({3{write_byte}}),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

endmodule

`default_nettype wire
